// ===== rtl/ccu_pkg.sv =====
// Package: shared widths, reset values, register indexes and phase codes.
`timescale 1ns / 1ps
`default_nettype none

package ccu_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 10;
  localparam int unsigned BATT_W          = 16;
  localparam int unsigned SP_W            = 14;
  localparam int unsigned SHIFT_W         = 3;
  localparam int unsigned DEG_W           = 10;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam logic [BATT_W-1:0]  STOP_LEVEL_RST  = 16'd52000;
  localparam logic [BATT_W-1:0]  START_LEVEL_RST = 16'd48000;
  localparam logic [SHIFT_W-1:0] SHIFT_RST       = 3'd3;
  localparam logic [DEG_W-1:0]   SP_MIN_RST      = 10'd50;
  localparam logic [DEG_W-1:0]   SP_MAX_RST      = 10'd250;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STOP_LEVEL  = 3'd0,
    REG_START_LEVEL = 3'd1,
    REG_AVG_SHIFT   = 3'd2,
    REG_SP_MIN      = 3'd3,
    REG_SP_MAX      = 3'd4
  } ccu_reg_e;

  typedef enum logic [1:0] {
    PH_BATT_START = 2'd0,
    PH_BATT_WAIT  = 2'd1,
    PH_SP_START   = 2'd2,
    PH_SP_WAIT    = 2'd3
  } ccu_phase_e;

  // control travelling with a request from the front pipeline to the core
  typedef struct packed {
    logic valid;
    logic done;
  } ccu_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ccu_ema.sv =====
// Exponential moving average step: avg + ((x - avg) >>> shift).
`timescale 1ns / 1ps
`default_nettype none

module ccu_ema #(
  parameter int unsigned W = ccu_pkg::BATT_W
) (
  input  logic [W-1:0]                avg_i,
  input  logic [W-1:0]                x_i,
  input  logic [ccu_pkg::SHIFT_W-1:0] shift_i,
  output logic [W-1:0]                avg_o
);

  logic signed [W:0] diff;
  logic signed [W:0] step;

  assign diff  = $signed({1'b0, x_i}) - $signed({1'b0, avg_i});
  // arithmetic shift rounds toward minus infinity
  assign step  = diff >>> shift_i;
  // result lands between avg and x, so the low W bits are exact
  assign avg_o = avg_i + step[W-1:0];

endmodule

`default_nettype wire

// ===== rtl/ccu_front.sv =====
// Front pipeline: input register, setpoint span multiply, divide by full scale.
`timescale 1ns / 1ps
`default_nettype none

module ccu_front #(
  parameter int unsigned SAMPLE_BITS = ccu_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            conv_done_i,
  input  logic [SAMPLE_BITS-1:0]          sample_i,
  input  logic [ccu_pkg::DEG_W-1:0]       sp_min_i,
  input  logic [ccu_pkg::DEG_W-1:0]       sp_max_i,
  output ccu_pkg::ccu_ctl_t               ctl_o,
  output logic [SAMPLE_BITS-1:0]          sample_o,
  output logic [ccu_pkg::SP_W-1:0]        target_o,
  input  logic                            ready_i
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned SPW   = ccu_pkg::SP_W;
  localparam int unsigned PW    = SPW + SB;
  localparam int unsigned RW    = ((SB > SPW) ? SB : SPW) + 1;
  localparam logic [RW-1:0] FULL = RW'((64'd1 << SB) - 64'd1);

  // stage valids and loads
  logic v0_q, v1_q, v2_q;
  logic rdy0, rdy1, rdy2;

  logic          done0_q, done1_q, done2_q;
  logic [SB-1:0] smp0_q, smp1_q, smp2_q;
  logic [PW-1:0] prod_q;
  logic [SPW-1:0] target_q;

  logic                     desc;
  logic [ccu_pkg::DEG_W-1:0] deg_diff;
  logic [SPW-1:0]           span;
  logic [SPW-1:0]           base;
  logic [PW-1:0]            prod_d;

  logic [RW-1:0] a1, r1, a2, r2, a3, r3, quo;
  logic [SPW-1:0] target_d;

  assign rdy2       = !v2_q || ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign rdy0       = !v0_q || rdy1;
  assign in_stall_o = !rdy0;

  // span in sixteenths of a degree; the user must hold config steady while requests are in flight (not enforced)
  assign desc     = sp_max_i < sp_min_i;
  assign deg_diff = desc ? (sp_min_i - sp_max_i) : (sp_max_i - sp_min_i);
  assign span     = {deg_diff, 4'b0000};
  assign base     = {sp_min_i, 4'b0000};
  assign prod_d   = PW'(span) * PW'(smp0_q);

  // floor(p / (2^SB - 1)) by folding the high part back into the low part
  always_comb begin
    a1  = RW'(prod_q[PW-1:SB]);
    r1  = a1 + RW'(prod_q[SB-1:0]);
    a2  = r1 >> SB;
    r2  = a2 + RW'(r1[SB-1:0]);
    a3  = r2 >> SB;
    r3  = a3 + RW'(r2[SB-1:0]);
    quo = a1 + a2 + a3 + RW'(r3 >= FULL);
    target_d = desc ? (base - quo[SPW-1:0]) : (base + quo[SPW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      done0_q <= conv_done_i;
      smp0_q  <= sample_i;
    end
    if (rdy1) begin
      done1_q <= done0_q;
      smp1_q  <= smp0_q;
      prod_q  <= prod_d;
    end
    if (rdy2) begin
      done2_q  <= done1_q;
      smp2_q   <= smp1_q;
      target_q <= target_d;
    end
  end

  assign ctl_o.valid = v2_q;
  assign ctl_o.done  = done2_q;
  assign sample_o    = smp2_q;
  assign target_o    = target_q;

endmodule

`default_nettype wire

// ===== rtl/ccu_core.sv =====
// Core: phase sequencer, both moving averages, relay hysteresis, result register.
`timescale 1ns / 1ps
`default_nettype none

module ccu_core #(
  parameter int unsigned SAMPLE_BITS = ccu_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ccu_pkg::ccu_ctl_t             ctl_i,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  input  logic [ccu_pkg::SP_W-1:0]      target_i,
  output logic                          ready_o,
  input  logic [ccu_pkg::BATT_W-1:0]    stop_level_i,
  input  logic [ccu_pkg::BATT_W-1:0]    start_level_i,
  input  logic [ccu_pkg::SHIFT_W-1:0]   avg_shift_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          start_conv_o,
  output logic                          channel_sel_o,
  output logic                          charge_relay_o,
  output logic [ccu_pkg::BATT_W-1:0]    battery_level_o,
  output logic [ccu_pkg::SP_W-1:0]      setpoint_level_o
);

  localparam int unsigned BW        = ccu_pkg::BATT_W;
  localparam int unsigned SPW       = ccu_pkg::SP_W;
  localparam int unsigned BATT_SHIFT = BW - SAMPLE_BITS;

  ccu_pkg::ccu_phase_e phase_q, phase_d;
  logic           out_valid_q, out_valid_d;
  logic           start_q, start_d;
  logic           relay_q, relay_d;
  logic [BW-1:0]  batt_q, batt_d, batt_new;
  logic [SPW-1:0] sp_q, sp_d, sp_new;
  logic [BW-1:0]  batt_x;
  logic           adv;

  assign ready_o = !out_valid_q || !out_stall_i;
  assign adv     = ctl_i.valid && ready_o;
  assign batt_x  = BW'(sample_i) << BATT_SHIFT;

  ccu_ema #(.W(BW)) u_batt_ema (
    .avg_i   (batt_q),
    .x_i     (batt_x),
    .shift_i (avg_shift_i),
    .avg_o   (batt_new)
  );

  ccu_ema #(.W(SPW)) u_sp_ema (
    .avg_i   (sp_q),
    .x_i     (target_i),
    .shift_i (avg_shift_i),
    .avg_o   (sp_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ccu_pkg::PH_BATT_START;
      out_valid_q <= 1'b0;
      start_q     <= 1'b0;
      relay_q     <= 1'b0;
      batt_q      <= '0;
      sp_q        <= '0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      start_q     <= start_d;
      relay_q     <= relay_d;
      batt_q      <= batt_d;
      sp_q        <= sp_d;
    end
  end

  // state registers double as the result register: they only move with a request
  always_comb begin
    phase_d     = phase_q;
    start_d     = start_q;
    relay_d     = relay_q;
    batt_d      = batt_q;
    sp_d        = sp_q;
    out_valid_d = ready_o ? adv : out_valid_q;
    if (adv) begin
      start_d = 1'b0;
      unique case (phase_q)
        ccu_pkg::PH_BATT_START: begin
          start_d = 1'b1;
          phase_d = ccu_pkg::PH_BATT_WAIT;
        end
        ccu_pkg::PH_BATT_WAIT: begin
          if (ctl_i.done) begin
            batt_d  = batt_new;
            // stop test first, it wins when the levels overlap
            if (batt_new >= stop_level_i) begin
              relay_d = 1'b0;
            end else if (batt_new <= start_level_i) begin
              relay_d = 1'b1;
            end
            phase_d = ccu_pkg::PH_SP_START;
          end
        end
        ccu_pkg::PH_SP_START: begin
          start_d = 1'b1;
          phase_d = ccu_pkg::PH_SP_WAIT;
        end
        ccu_pkg::PH_SP_WAIT: begin
          if (ctl_i.done) begin
            sp_d    = sp_new;
            phase_d = ccu_pkg::PH_BATT_START;
          end
        end
        default: begin
          phase_d = ccu_pkg::PH_BATT_START;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign start_conv_o     = start_q;
  assign channel_sel_o    = phase_q[1];
  assign charge_relay_o   = relay_q;
  assign battery_level_o  = batt_q;
  assign setpoint_level_o = sp_q;

endmodule

`default_nettype wire

// ===== rtl/two_channel_average_charge_control_unit.sv =====
// Top level: two-channel converter sequencer with averaging and charge relay.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------
//  in      | to block  | in_valid_i / in_stall_o  | conv_done_i, sample_i
//  out     | from block| out_valid_o / out_stall_i| start_conv_o, channel_sel_o,
//          |           |                          | charge_relay_o, battery_level_o,
//          |           |                          | setpoint_level_o
//  cfg     | to block  | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One request per cycle sustained while out_stall_i stays low; a request taken into the input
// register passes the span multiply, divide by full scale and state update registers in turn.
// The state update stage is the only loop.
// Reset clears phase, both averages and the relay; config returns to defaults.
// An output stall holds the result; the front stages keep filling until full.
// cfg_ready_o is always high.
`timescale 1ns / 1ps
`default_nettype none

module two_channel_average_charge_control_unit #(
  parameter int unsigned SAMPLE_BITS = ccu_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              conv_done_i,
  input  logic [SAMPLE_BITS-1:0]            sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              start_conv_o,
  output logic                              channel_sel_o,
  output logic                              charge_relay_o,
  output logic [ccu_pkg::BATT_W-1:0]        battery_level_o,
  output logic [ccu_pkg::SP_W-1:0]          setpoint_level_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ccu_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ccu_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic [ccu_pkg::BATT_W-1:0]  stop_level_q;
  logic [ccu_pkg::BATT_W-1:0]  start_level_q;
  logic [ccu_pkg::SHIFT_W-1:0] avg_shift_q;
  logic [ccu_pkg::DEG_W-1:0]   sp_min_q;
  logic [ccu_pkg::DEG_W-1:0]   sp_max_q;

  ccu_pkg::ccu_ctl_t           ctl;
  logic [SAMPLE_BITS-1:0]      front_sample;
  logic [ccu_pkg::SP_W-1:0]    front_target;
  logic                        core_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_level_q  <= ccu_pkg::STOP_LEVEL_RST;
      start_level_q <= ccu_pkg::START_LEVEL_RST;
      avg_shift_q   <= ccu_pkg::SHIFT_RST;
      sp_min_q      <= ccu_pkg::SP_MIN_RST;
      sp_max_q      <= ccu_pkg::SP_MAX_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ccu_pkg::ccu_reg_e'(cfg_index_i))
        ccu_pkg::REG_STOP_LEVEL:  stop_level_q  <= cfg_data_i;
        ccu_pkg::REG_START_LEVEL: start_level_q <= cfg_data_i;
        ccu_pkg::REG_AVG_SHIFT:   avg_shift_q   <= cfg_data_i[ccu_pkg::SHIFT_W-1:0];
        ccu_pkg::REG_SP_MIN:      sp_min_q      <= cfg_data_i[ccu_pkg::DEG_W-1:0];
        ccu_pkg::REG_SP_MAX:      sp_max_q      <= cfg_data_i[ccu_pkg::DEG_W-1:0];
        default: ;
      endcase
    end
  end

  ccu_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .conv_done_i (conv_done_i),
    .sample_i    (sample_i),
    .sp_min_i    (sp_min_q),
    .sp_max_i    (sp_max_q),
    .ctl_o       (ctl),
    .sample_o    (front_sample),
    .target_o    (front_target),
    .ready_i     (core_ready)
  );

  ccu_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .sample_i         (front_sample),
    .target_i         (front_target),
    .ready_o          (core_ready),
    .stop_level_i     (stop_level_q),
    .start_level_i    (start_level_q),
    .avg_shift_i      (avg_shift_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .start_conv_o     (start_conv_o),
    .channel_sel_o    (channel_sel_o),
    .charge_relay_o   (charge_relay_o),
    .battery_level_o  (battery_level_o),
    .setpoint_level_o (setpoint_level_o)
  );

endmodule

`default_nettype wire
